FILE: src/isodr_pkg.sv
// isodr_pkg: shared types and constants for the directory record scanner
// no dependencies; imported by the scanner top level and its checker
package isodr_pkg;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_EXPECT = 2'd1;
    localparam logic [1:0] PH_INREC  = 2'd2;
    localparam logic [1:0] PH_PAD    = 2'd3;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_DIR_SIZE = 3'd1;
    localparam logic [2:0] REG_TINDEX   = 3'd2;
    localparam logic [2:0] REG_TLEN     = 3'd3;
    localparam logic [2:0] REG_TWORD0   = 3'd4;
    localparam logic [2:0] REG_TWORD1   = 3'd5;
    localparam logic [2:0] REG_TWORD2   = 3'd6;
    localparam logic [2:0] REG_TWORD3   = 3'd7;

    // byte offsets inside a directory record
    localparam logic [7:0] OFF_EXTENT   = 8'd2;
    localparam logic [7:0] OFF_SIZE     = 8'd10;
    localparam logic [7:0] OFF_FLAGS    = 8'd25;
    localparam logic [7:0] OFF_NAME_LEN = 8'd32;
    localparam logic [7:0] OFF_NAME     = 8'd33;
    localparam logic [7:0] MIN_REC_LEN  = 8'd34;
    localparam logic [7:0] NO_MISMATCH  = 8'd255;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int OUT_W = 80;

    typedef logic [31:0][7:0] t_tchars;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= CH_UPA && c <= CH_UPZ) ? c + CASE_OFS : c;
    endfunction

endpackage

FILE: src/isodr_ram.sv
// isodr_ram: generic single write port ram with registered read
// no dependencies
module isodr_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/iso9660_directory_record_scanner_top.sv
// Directory record scanner: takes one extent byte per cycle and answers each scan with a
// found / not found / malformed result; in index mode a found record with a visible name
// streams it lowercased, one character per result. An input byte is accepted in every
// cycle while the result register is free or being drained. While a name is streamed
// (up to NAME_CAP-1 results, one per cycle, paced by the name store's read port and
// the output handshake) no byte is accepted.
// depends on isodr_pkg and isodr_ram
module iso9660_directory_record_scanner_top
    import isodr_pkg::*;
#(
    parameter int BLOCK_BYTES  = 2048,
    parameter int TARGET_CHARS = 32,
    parameter int NAME_CAP     = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // data_byte
    input  logic              i_s_axis_tuser,   // start_req
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // status[1:0], is_directory[2], extent_block[34:3], data_size[66:35],
    // name_char[74:67], zero[79:75]
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_addr,
    input  logic [63:0]       i_cfg_data
);
    localparam int PW = $clog2(BLOCK_BYTES);
    localparam int AW = $clog2(NAME_CAP);
    localparam logic [PW:0]   BLK      = (PW+1)'(BLOCK_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(BLOCK_BYTES - 1);
    localparam logic [AW-1:0] CNT_MAX  = AW'(NAME_CAP - 1);
    localparam logic [5:0]    TC       = 6'(TARGET_CHARS);

    logic        r_mode;
    logic [31:0] r_dir_size, r_tindex;
    logic [5:0]  r_tlen;
    t_tchars     r_tchars;

    logic [1:0]    r_phase, n_phase;
    logic [31:0]   r_base, n_base;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_rl, n_rl, r_ro, n_ro, r_nl, n_nl, r_vis, n_vis, r_mm, n_mm;
    logic          r_dir, n_dir, r_cut, n_cut;
    logic [31:0]   r_ext, n_ext, r_size, n_size, r_ord, n_ord;

    logic          r_emit, n_emit, r_rd_ok;
    logic [AW-1:0] r_idx, n_idx, r_cnt, n_cnt, w_raddr;
    logic [7:0]    w_rdata;

    logic          r_ovalid;
    logic [1:0]    r_o_status;
    logic          r_o_dir, r_o_last;
    logic [31:0]   r_o_ext, r_o_size;
    logic [7:0]    r_o_char;

    logic       w_acc, w_out_free, w_emit_ld;
    logic       res_ld, res_rec;
    logic [1:0] res_status;
    logic       w_we;
    logic [8:0] w_ci;
    logic [5:0] w_tl_cap, w_tlen, w_vis1, w_tvis;

    assign o_cfg_ready     = 1'b1;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = !r_emit && w_out_free;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit_ld       = r_emit && r_rd_ok && w_out_free;
    assign w_raddr         = w_emit_ld ? r_idx + 1'b1 : r_idx;

    // target name length and visible length
    always_comb begin
        w_tl_cap = (r_tlen > TC) ? TC : r_tlen;
        w_tlen   = w_tl_cap;
        for (int i = 31; i >= 0; i--) begin
            if (6'(i) < w_tl_cap && r_tchars[i] == 8'd0) w_tlen = 6'(i);
        end
        w_vis1 = w_tlen;
        for (int i = 31; i >= 0; i--) begin
            if (7'(i) + 7'd1 < {1'b0, w_tlen} && r_tchars[i] == CH_SEMI) w_vis1 = 6'(i);
        end
        w_tvis = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (6'(i) < w_vis1 && r_tchars[i] != CH_DOT) w_tvis = 6'(i + 1);
        end
    end

    always_comb begin
        logic [1:0] ph;
        logic       done;
        logic [7:0] b;
        logic [7:0] ci;
        logic       hit;
        n_phase = r_phase; n_base = r_base; n_pos = r_pos; n_rl = r_rl; n_ro = r_ro;
        n_nl = r_nl; n_vis = r_vis; n_mm = r_mm; n_dir = r_dir; n_cut = r_cut;
        n_ext = r_ext; n_size = r_size; n_ord = r_ord;
        n_emit = r_emit; n_idx = r_idx; n_cnt = r_cnt;
        res_ld = 1'b0; res_rec = 1'b0; res_status = ST_FOUND;
        w_we = 1'b0; w_ci = 9'd0;
        b = i_s_axis_tdata; done = 1'b0; hit = 1'b0; ph = PH_IDLE; ci = 8'd0;

        if (w_emit_ld) begin
            n_idx = r_idx + 1'b1;
            if (r_idx + 1'b1 == r_cnt) n_emit = 1'b0;
        end

        if (w_acc && (i_s_axis_tuser || r_phase != PH_IDLE)) begin
            if (i_s_axis_tuser) begin
                n_base = '0; n_pos = '0; n_rl = '0; n_ro = '0; n_nl = '0; n_vis = '0;
                n_mm = '0; n_dir = 1'b0; n_cut = 1'b0; n_ext = '0; n_size = '0;
                n_ord = '0; n_phase = PH_EXPECT;
            end
            if (i_s_axis_tuser && (r_dir_size == 32'd0 || (!r_mode && w_tlen == 6'd0))) begin
                res_ld = 1'b1; res_status = ST_NOTFOUND; n_phase = PH_IDLE; done = 1'b1;
            end else begin
                ph = (n_pos == '0) ? PH_EXPECT : n_phase;
                n_phase = ph;
                case (ph)
                    PH_EXPECT: begin
                        if ({1'b0, n_base} + 33'(n_pos) >= {1'b0, r_dir_size} || b == 8'd0) begin
                            n_phase = PH_PAD;
                        end else if (b < MIN_REC_LEN || {1'b0, n_pos} + (PW+1)'(b) > BLK) begin
                            res_ld = 1'b1; res_status = ST_BAD; n_phase = PH_IDLE; done = 1'b1;
                        end else begin
                            n_rl = b; n_ro = 8'd1; n_nl = '0; n_dir = 1'b0; n_ext = '0;
                            n_size = '0; n_vis = '0; n_mm = NO_MISMATCH; n_cut = 1'b0;
                            n_phase = PH_INREC;
                        end
                    end
                    PH_INREC: begin
                        if (r_ro >= OFF_EXTENT && r_ro < OFF_EXTENT + 8'd4) begin
                            n_ext[8*(2'(r_ro - OFF_EXTENT)) +: 8] = b;
                        end else if (r_ro >= OFF_SIZE && r_ro < OFF_SIZE + 8'd4) begin
                            n_size[8*(2'(r_ro - OFF_SIZE)) +: 8] = b;
                        end else if (r_ro == OFF_FLAGS) begin
                            n_dir = b[1];
                        end else if (r_ro == OFF_NAME_LEN) begin
                            if (b == 8'd0 || 9'(OFF_NAME) + 9'(b) > 9'(r_rl)) begin
                                res_ld = 1'b1; res_status = ST_BAD; n_phase = PH_IDLE;
                                done = 1'b1;
                            end else begin
                                n_nl = b;
                            end
                        end else if (r_ro >= OFF_NAME && 9'(r_ro) < 9'(OFF_NAME) + 9'(r_nl)) begin
                            ci   = r_ro - OFF_NAME;
                            w_ci = 9'(ci);
                            w_we = w_ci < 9'(NAME_CAP);
                            if (w_ci < 9'(TARGET_CHARS) && r_mm == NO_MISMATCH &&
                                to_lower(b) != to_lower(r_tchars[ci[4:0]])) begin
                                n_mm = ci;
                            end
                            if (!r_cut) begin
                                if (b == CH_SEMI && 9'(ci) + 9'd1 < 9'(r_nl)) n_cut = 1'b1;
                                else if (b != CH_DOT) n_vis = ci + 8'd1;
                            end
                        end
                        if (!done && 9'(r_ro) + 9'd1 >= 9'(r_rl)) begin
                            n_phase = PH_EXPECT;
                            if (n_nl > 8'd1) begin
                                if (!r_mode) begin
                                    hit = n_vis != 8'd0 && n_vis == 8'(w_tvis) && n_mm >= n_vis;
                                end else if (r_ord == r_tindex) begin
                                    hit = 1'b1;
                                end else begin
                                    n_ord = r_ord + 32'd1;
                                end
                            end
                            if (hit) begin
                                n_phase = PH_IDLE; done = 1'b1;
                                if (r_mode && n_vis != 8'd0) begin
                                    n_emit = 1'b1; n_idx = '0;
                                    n_cnt  = (n_vis > 8'(CNT_MAX)) ? CNT_MAX : n_vis[AW-1:0];
                                end else begin
                                    res_ld = 1'b1; res_rec = 1'b1; res_status = ST_FOUND;
                                end
                            end
                        end
                        n_ro = r_ro + 8'd1;
                    end
                    default: begin
                    end
                endcase
                if (!done) begin
                    if ({1'b0, n_base} >= {1'b0, r_dir_size} ||
                        (n_pos == POS_LAST &&
                         {1'b0, n_base} + 33'(BLOCK_BYTES) >= {1'b0, r_dir_size})) begin
                        res_ld = 1'b1; res_status = ST_NOTFOUND; n_phase = PH_IDLE;
                    end else if (n_pos == POS_LAST) begin
                        n_pos  = '0;
                        n_base = n_base + 32'(BLOCK_BYTES);
                    end else begin
                        n_pos = n_pos + 1'b1;
                    end
                end
            end
        end
    end

    isodr_ram #(.W(8), .D(NAME_CAP)) u_name (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ci[AW-1:0]),
        .i_wdata (to_lower(i_s_axis_tdata)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_dir_size <= 32'd2048; r_tindex <= '0; r_tlen <= '0;
            r_tchars <= '0;
            r_phase <= PH_IDLE; r_emit <= 1'b0; r_rd_ok <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    REG_MODE:     r_mode           <= i_cfg_data[0];
                    REG_DIR_SIZE: r_dir_size       <= i_cfg_data[31:0];
                    REG_TINDEX:   r_tindex         <= i_cfg_data[31:0];
                    REG_TLEN:     r_tlen           <= i_cfg_data[5:0];
                    REG_TWORD0:   r_tchars[7:0]    <= i_cfg_data;
                    REG_TWORD1:   r_tchars[15:8]   <= i_cfg_data;
                    REG_TWORD2:   r_tchars[23:16]  <= i_cfg_data;
                    REG_TWORD3:   r_tchars[31:24]  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase;
            r_emit  <= n_emit;
            r_rd_ok <= n_emit && !(w_acc && n_emit && !r_emit);
            if (res_ld || w_emit_ld) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base; r_pos <= n_pos; r_rl <= n_rl; r_ro <= n_ro; r_nl <= n_nl;
        r_vis <= n_vis; r_mm <= n_mm; r_dir <= n_dir; r_cut <= n_cut; r_ext <= n_ext;
        r_size <= n_size; r_ord <= n_ord; r_idx <= n_idx; r_cnt <= n_cnt;
        if (res_ld) begin
            r_o_status <= res_status;
            r_o_dir    <= res_rec ? n_dir : 1'b0;
            r_o_ext    <= res_rec ? n_ext : 32'd0;
            r_o_size   <= res_rec ? n_size : 32'd0;
            r_o_char   <= 8'd0;
            r_o_last   <= 1'b1;
        end else if (w_emit_ld) begin
            r_o_status <= ST_FOUND;
            r_o_dir    <= r_dir;
            r_o_ext    <= r_ext;
            r_o_size   <= r_size;
            r_o_char   <= w_rdata;
            r_o_last   <= (r_idx + 1'b1 == r_cnt);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {5'd0, r_o_char, r_o_size, r_o_ext, r_o_dir, r_o_status};
endmodule

FILE: src/isodr_checker.sv
// isodr_checker: port level assertions for the directory record scanner
// depends on isodr_pkg; bound to iso9660_directory_record_scanner_top
module isodr_checker
    import isodr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_FOUND |-> o_m_axis_tlast)
        else $error("failure answer not single");

    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_FOUND
        |-> o_m_axis_tdata[74:2] == 73'd0)
        else $error("failure answer carries record data");
endmodule

bind iso9660_directory_record_scanner_top isodr_checker u_isodr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
